[hdl/ahw_pkg.sv]
// Shared constants and tables for the angular hue wheel pixel pipeline.
`default_nettype none
package ahw_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int DX_W = 11;
   localparam int DY_W = 10;
   localparam int VEC_W = 30;
   localparam int ANG_W = 24;
   localparam int PH_W = 16;
   localparam int ROT_W = 32;
   localparam int FOLD_W = 25;
   localparam int NUM_LANES = 3;
   // input register, vectoring, rotation, multiply and output stages
   localparam int AHW_LATENCY = 2 * CORDIC_STEPS + 6;

   localparam logic [ANG_W-1:0] HALF_TURN = 24'h800000;
   localparam logic signed [FOLD_W-1:0] QUARTER_TURN = 25'sd4194304;
   localparam logic signed [FOLD_W-1:0] HALF_TURN_S = 25'sd8388608;
   localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [33:0] ONE_Q30_BIAS = 34'sd1073745920; // 2^30 + 2^12
   localparam logic [PH_W-1:0] THIRD_TURN16 = 16'd21845;
   localparam logic [ANG_W-1:0] ROUND_HALF = 24'd128;

   localparam logic [ANG_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
      24'd166669, 24'd83416, 24'd41718, 24'd20860,
      24'd10430, 24'd5215, 24'd2608, 24'd1304,
      24'd652, 24'd326, 24'd163, 24'd81
   };

   localparam logic [0:0] REG_CENTER_X = 1'b0;
   localparam logic [0:0] REG_CENTER_Y = 1'b1;

endpackage
`default_nettype wire

[hdl/ahw_vector.sv]
// Vectoring CORDIC: one iteration per stage, angle of (dx, dy) in 16-bit turns.
`default_nettype none
module ahw_vector
   import ahw_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  wire signed [DX_W-1:0]   in_dx,
   input  wire signed [DY_W-1:0]   in_dy,
   output logic                    out_valid,
   output logic [PH_W-1:0]         out_phase [NUM_LANES]
);

   logic                    vld_ff  [0:CORDIC_STEPS];
   logic                    zero_ff [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] x_ff    [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] y_ff    [0:CORDIC_STEPS];
   logic [ANG_W-1:0]        z_ff    [0:CORDIC_STEPS];
   logic                    t_vld_ff;
   logic [PH_W-1:0]         ph_ff [NUM_LANES];

   logic signed [VEC_W-1:0] x_pre;
   logic signed [VEC_W-1:0] y_pre;
   logic [ANG_W-1:0]        z_sum;
   logic [PH_W-1:0]         t_in;

   assign x_pre = VEC_W'(signed'({in_dx, 16'h0000})) ;
   assign y_pre = VEC_W'(signed'({in_dy, 16'h0000})) ;

   // left half-plane vectors get a half turn up front
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      zero_ff[0] <= (in_dx == '0) && (in_dy == '0);
      if (in_dx < 0) begin
         x_ff[0] <= -(x_pre | VEC_W'(0)) ;
         y_ff[0] <= -y_pre;
         z_ff[0] <= HALF_TURN;
      end else begin
         x_ff[0] <= x_pre;
         y_ff[0] <= y_pre;
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         zero_ff[i+1] <= zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ATAN_TABLE[i];
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ATAN_TABLE[i];
         end
      end
   end

   assign z_sum = z_ff[CORDIC_STEPS] + ROUND_HALF;
   assign t_in  = zero_ff[CORDIC_STEPS] ? '0 : z_sum[ANG_W-1:ANG_W-PH_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else begin
         t_vld_ff <= vld_ff[CORDIC_STEPS];
      end
      ph_ff[0] <= t_in;
      ph_ff[1] <= t_in + THIRD_TURN16;
      ph_ff[2] <= t_in - THIRD_TURN16;
   end

   assign out_valid = t_vld_ff;
   assign out_phase = ph_ff;

endmodule
`default_nettype wire

[hdl/ahw_cosine.sv]
// Rotation CORDIC lanes and the cos-squared to 8-bit channel scaling.
`default_nettype none
module ahw_cosine
   import ahw_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   input  wire [PH_W-1:0]   in_phase [NUM_LANES],
   output logic             out_valid,
   output logic [7:0]       out_level [NUM_LANES]
);

   logic                     vld_ff [0:CORDIC_STEPS];
   logic                     mul_vld_ff;
   logic                     out_vld_ff;
   logic                     flip_ff [NUM_LANES][0:CORDIC_STEPS];
   logic signed [ROT_W-1:0]  x_ff [NUM_LANES][0:CORDIC_STEPS];
   logic signed [ROT_W-1:0]  y_ff [NUM_LANES][0:CORDIC_STEPS];
   logic signed [FOLD_W-1:0] a_ff [NUM_LANES][0:CORDIC_STEPS];
   logic [40:0]              prod_ff [NUM_LANES];
   logic [7:0]               level_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0]  <= 1'b0;
         mul_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff[0]  <= in_valid;
         mul_vld_ff <= vld_ff[CORDIC_STEPS];
         out_vld_ff <= mul_vld_ff;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic signed [FOLD_W-1:0] a_start;
      logic signed [ROT_W:0]    c_val;
      logic signed [33:0]       n_val;
      logic [32:0]              n_pos;
      logic [9:0]               v_val;

      assign a_start = FOLD_W'(signed'({in_phase[l], 8'h00}));

      // fold into +/- quarter turn; a removed half turn flips the sign
      always_ff @(posedge clock) begin
         x_ff[l][0] <= INV_GAIN_Q30;
         y_ff[l][0] <= '0;
         if (a_start > QUARTER_TURN) begin
            a_ff[l][0]    <= a_start - HALF_TURN_S;
            flip_ff[l][0] <= 1'b1;
         end else if (a_start < -QUARTER_TURN) begin
            a_ff[l][0]    <= a_start + HALF_TURN_S;
            flip_ff[l][0] <= 1'b1;
         end else begin
            a_ff[l][0]    <= a_start;
            flip_ff[l][0] <= 1'b0;
         end
      end

      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
         always_ff @(posedge clock) begin
            flip_ff[l][i+1] <= flip_ff[l][i];
            if (a_ff[l][i] >= 0) begin
               x_ff[l][i+1] <= x_ff[l][i] - (y_ff[l][i] >>> i);
               y_ff[l][i+1] <= y_ff[l][i] + (x_ff[l][i] >>> i);
               a_ff[l][i+1] <= a_ff[l][i] - FOLD_W'(ATAN_TABLE[i]);
            end else begin
               x_ff[l][i+1] <= x_ff[l][i] + (y_ff[l][i] >>> i);
               y_ff[l][i+1] <= y_ff[l][i] - (x_ff[l][i] >>> i);
               a_ff[l][i+1] <= a_ff[l][i] + FOLD_W'(ATAN_TABLE[i]);
            end
         end
      end

      assign c_val = flip_ff[l][CORDIC_STEPS] ?
                     -(ROT_W+1)'(x_ff[l][CORDIC_STEPS]) :
                     (ROT_W+1)'(x_ff[l][CORDIC_STEPS]);
      assign n_val = ONE_Q30_BIAS + 34'(c_val);
      assign n_pos = n_val[33] ? '0 : n_val[32:0];
      assign v_val = prod_ff[l][40:31];

      always_ff @(posedge clock) begin
         prod_ff[l]  <= 41'(n_pos) * 41'd255;
         level_ff[l] <= (v_val > 10'd255) ? 8'hFF : v_val[7:0];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_level = level_ff;

endmodule
`default_nettype wire

[hdl/angular_hue_wheel_pixel.sv]
// Top level: angular hue wheel pixel colorizer with APB center registers.
//
// Usage: pulse start with req_x_coord/req_y_coord to hand in one pixel word.
// busy is tied low, so a new word is taken on every clock edge with start
// high. Each word yields one result word (rsp_red, rsp_green, rsp_blue),
// shown for one cycle with rsp_valid high; rsp_valid rises once the word
// has passed the input, vectoring, rotation, multiply and output stages.
// Throughput is one pixel per clock: a 16-stage vectoring CORDIC finds the
// angle, three 16-stage rotation CORDIC lanes form the cosines, and a
// multiply stage scales them to 8 bits; every stage holds one pixel.
// The receiver cannot stall; results must be taken when rsp_valid is high.
// Reset clears all valid bits in the pipe, drops words in flight, and sets
// the center to the middle of the frame. The center registers sit at byte
// addresses 0 (center_x) and 4 (center_y); write them only while no pixel
// is in flight.
`default_nettype none
module angular_hue_wheel_pixel
   import ahw_pkg::*;
#(
   parameter int FRAME_WIDTH  = 640,
   parameter int FRAME_HEIGHT = 480
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [9:0]  req_x_coord,
   input  wire  [8:0]  req_y_coord,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [9:0]            center_x_ff;
   logic [8:0]            center_y_ff;
   logic                  in_vld_ff;
   logic signed [DX_W-1:0] dx_ff;
   logic signed [DY_W-1:0] dy_ff;
   logic                  cfg_wr;
   logic                  vec_valid;
   logic [PH_W-1:0]       vec_phase [NUM_LANES];
   logic [7:0]            level [NUM_LANES];

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= 10'(FRAME_WIDTH / 2);
         center_y_ff <= 9'(FRAME_HEIGHT / 2);
      end else if (cfg_wr) begin
         unique case (paddr[2])
            REG_CENTER_X: center_x_ff <= pwdata[9:0];
            REG_CENTER_Y: center_y_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CENTER_X: prdata = {22'h0, center_x_ff};
         REG_CENTER_Y: prdata = {23'h0, center_y_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start & ~busy;
      end
      dx_ff <= signed'({1'b0, req_x_coord}) - signed'({1'b0, center_x_ff});
      dy_ff <= signed'({1'b0, req_y_coord}) - signed'({1'b0, center_y_ff});
   end

   ahw_vector u_vector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld_ff),
      .in_dx     (dx_ff),
      .in_dy     (dy_ff),
      .out_valid (vec_valid),
      .out_phase (vec_phase)
   );

   ahw_cosine u_cosine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vec_valid),
      .in_phase  (vec_phase),
      .out_valid (rsp_valid),
      .out_level (level)
   );

   assign rsp_red   = level[0];
   assign rsp_green = level[1];
   assign rsp_blue  = level[2];

endmodule
`default_nettype wire

[hdl/ahw_checker.sv]
// Port-level checker for the hue wheel pipeline, bound to the top level.
`default_nettype none
module ahw_checker
   import ahw_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        rsp_valid,
   input wire        pready
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##AHW_LATENCY rsp_valid)
      else $error("result word missing");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##AHW_LATENCY !rsp_valid)
      else $error("result word without request");

   a_ready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind angular_hue_wheel_pixel ahw_checker u_ahw_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .pready    (pready)
);
`default_nettype wire
